>>> hw/rtl/pls_pkg.sv
// shared types and codes for the positional list store
package pls_pkg;

   typedef enum logic [2:0] {
      ACT_INSERT   = 3'd0,
      ACT_REMOVE   = 3'd1,
      ACT_RETRIEVE = 3'd2,
      ACT_REPLACE  = 3'd3,
      ACT_CLEAR    = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   localparam int ACTION_W = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 7;

endpackage

>>> hw/rtl/positional_list_store_core.sv
// top level of the positional list store
//
// positional list store: an ordered list of up to DEPTH words addressed by
// position. each request carries an action (insert, remove, retrieve, replace,
// clear), a position and a value, and gives exactly one response with status,
// the value read and the list size afterwards. the entries live in one
// synchronous memory with a registered read and a single write port. insert and
// remove move entries one at a time through that memory: a pipelined
// read-then-write walk runs from the end of the list down to the position
// (insert) or from just above the removed position up to the end (remove),
// one entry per cycle. one request is worked at a time and req_stall is high
// until the sequencer is idle again. replace, clear, rejected requests and
// insert at the end of the list go straight to the response; retrieve first
// reads the entry; any other insert moves each entry from the end down to the
// position and then writes the new value; remove reads the entry and then
// moves each entry above it down. the response waits in an output register,
// and a stalled response holds the sequencer until it drains. entries that
// were never written are never read, so no clearing pass is needed after
// reset.
module positional_list_store_core #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pls_pkg::ACTION_W-1:0]  req_action,
   input  logic [pls_pkg::POS_W-1:0]     req_position,
   input  logic [pls_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pls_pkg::STATUS_W-1:0]  rsp_status,
   output logic [pls_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [pls_pkg::SIZE_W-1:0]    rsp_list_size
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = (DATA_WIDTH < pls_pkg::VALUE_W) ? DATA_WIDTH : pls_pkg::VALUE_W;
   // compare width: holds any position and any count without wrapping
   localparam int CMPW = ((pls_pkg::POS_W > CW) ? pls_pkg::POS_W : CW) + 1;

   // one-hot sequencer
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,  // read data back for retrieve / remove
      S_SHIFT = 5'b00100,  // move one entry per cycle
      S_PUT   = 5'b01000,  // insert: new value lands at its slot
      S_DONE  = 5'b10000   // post response
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        idx_ff, idx_in;     // walking address
   logic [AW-1:0]        pos_ff, pos_in;
   logic [DW-1:0]        val_ff, val_in;
   logic                 ins_ff, ins_in;     // shift direction / retrieve flag
   logic [DW-1:0]        rd_ff, rd_in;       // value for the response
   logic [pls_pkg::STATUS_W-1:0] st_ff, st_in;

   logic                 rv_ff, rv_in;
   logic [pls_pkg::STATUS_W-1:0] ost_ff, ost_in;
   logic [DW-1:0]        ord_ff, ord_in;
   logic [CW-1:0]        osz_ff, osz_in;

   // entry memory
   logic [DW-1:0]        mem [DEPTH];
   logic                 mwe;
   logic [AW-1:0]        mwa, mra;
   logic [DW-1:0]        mwd, mrd_ff;

   always_ff @(posedge clock) begin
      if (mwe) begin
         mem[mwa] <= mwd;
      end
      mrd_ff <= mem[mra];
   end

   logic            out_free;
   logic            take;
   logic [CMPW-1:0] pos_w;
   logic [CMPW-1:0] cnt_w;
   logic [CMPW-1:0] nxt_w;   // walking address plus one

   assign out_free  = !rv_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign take      = req_valid && (state_ff == S_IDLE);
   assign pos_w     = CMPW'(req_position);
   assign cnt_w     = CMPW'(count_ff);
   assign nxt_w     = CMPW'(idx_ff) + 1'b1;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      ins_in   = ins_ff;
      rd_in    = rd_ff;
      st_in    = st_ff;
      mwe = 1'b0;
      mwa = idx_ff;
      mwd = mrd_ff;
      mra = idx_ff;
      rv_in  = rv_ff && rsp_stall;
      ost_in = ost_ff;
      ord_in = ord_ff;
      osz_in = osz_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               pos_in = req_position[AW-1:0];
               val_in = req_value[DW-1:0];
               rd_in  = '0;
               st_in  = pls_pkg::ST_OK;
               mra    = req_position[AW-1:0];
               state_in = S_DONE;
               unique case (req_action)
                  pls_pkg::ACT_INSERT: begin
                     if (pos_w > cnt_w) begin
                        st_in = pls_pkg::ST_UNDER;
                     end else if (cnt_w >= CMPW'(DEPTH)) begin
                        st_in = pls_pkg::ST_OVER;
                     end else begin
                        ins_in = 1'b1;
                        count_in = count_ff + 1'b1;
                        if (pos_w == cnt_w) begin
                           // append: nothing to move
                           mwe = 1'b1;
                           mwa = req_position[AW-1:0];
                           mwd = req_value[DW-1:0];
                        end else begin
                           // move entry count-1 to count first, then downward
                           idx_in = AW'(count_ff - 1'b1);
                           mra    = AW'(count_ff - 1'b1);
                           state_in = S_SHIFT;
                        end
                     end
                  end
                  pls_pkg::ACT_REMOVE, pls_pkg::ACT_RETRIEVE: begin
                     if (pos_w >= cnt_w) begin
                        st_in = pls_pkg::ST_UNDER;
                     end else begin
                        ins_in = (req_action == pls_pkg::ACT_RETRIEVE);
                        idx_in = req_position[AW-1:0];
                        state_in = S_READ;
                     end
                  end
                  pls_pkg::ACT_REPLACE: begin
                     if (pos_w >= cnt_w) begin
                        st_in = pls_pkg::ST_UNDER;
                     end else begin
                        mwe = 1'b1;
                        mwa = req_position[AW-1:0];
                        mwd = req_value[DW-1:0];
                     end
                  end
                  pls_pkg::ACT_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         S_READ: begin
            rd_in = mrd_ff;
            if (ins_ff) begin
               state_in = S_DONE;
            end else begin
               // remove: pull entries above the position down by one
               count_in = count_ff - 1'b1;
               if (nxt_w >= cnt_w) begin
                  state_in = S_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  mra = idx_ff + 1'b1;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            mwe = 1'b1;
            mwd = mrd_ff;
            if (ins_ff) begin
               // insert walk: entry idx moves up to idx+1
               mwa = idx_ff + 1'b1;
               if (idx_ff == pos_ff) begin
                  state_in = S_PUT;
               end else begin
                  idx_in = idx_ff - 1'b1;
                  mra = idx_ff - 1'b1;
               end
            end else begin
               // remove walk: entry idx moves down to idx-1, count already lowered
               mwa = idx_ff - 1'b1;
               if (nxt_w > cnt_w) begin
                  state_in = S_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  mra = idx_ff + 1'b1;
               end
            end
         end
         S_PUT: begin
            mwe = 1'b1;
            mwa = pos_ff;
            mwd = val_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rv_in  = 1'b1;
               ost_in = st_ff;
               ord_in = rd_ff;
               osz_in = count_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      ins_ff <= ins_in;
      rd_ff  <= rd_in;
      st_ff  <= st_in;
      ost_ff <= ost_in;
      ord_ff <= ord_in;
      osz_ff <= osz_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = ost_ff;
   assign rsp_read_value = pls_pkg::VALUE_W'(ord_ff);
   assign rsp_list_size  = pls_pkg::SIZE_W'(osz_ff);

endmodule
